// ----- rtl/pda_pkg.sv -----
// pda_pkg: shared types, codes and character helpers for the direct address parser.
// No dependencies; used by pda_char_step and plc_direct_address_parser.

package pda_pkg;

    localparam int IndexWidthDefault = 64;

    // Parse phases
    localparam logic [2:0] PH_PREFIX     = 3'd0;
    localparam logic [2:0] PH_AFTER_CAT  = 3'd1;
    localparam logic [2:0] PH_AFTER_TYPE = 3'd2;
    localparam logic [2:0] PH_INDEX      = 3'd3;
    localparam logic [2:0] PH_DOT        = 3'd4;
    localparam logic [2:0] PH_BIT        = 3'd5;
    localparam logic [2:0] PH_FAIL       = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_FORMAT   = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW = 3'd2;
    localparam logic [2:0] ERR_BIT_RANGE = 3'd3;
    localparam logic [2:0] ERR_BIT_TYPE = 3'd4;

    // Category codes
    localparam logic [1:0] CAT_I = 2'd0;
    localparam logic [1:0] CAT_Q = 2'd1;
    localparam logic [1:0] CAT_M = 2'd2;
    localparam logic [1:0] CAT_S = 2'd3;

    // Data type codes
    localparam logic [2:0] DT_X = 3'd0;
    localparam logic [2:0] DT_B = 3'd1;
    localparam logic [2:0] DT_W = 3'd2;
    localparam logic [2:0] DT_D = 3'd3;
    localparam logic [2:0] DT_L = 3'd4;
    localparam logic [2:0] DT_R = 3'd5;
    localparam logic [2:0] DT_F = 3'd6;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] PERCENT_MAX = 2'd2;
    localparam logic [6:0] BIT_POS_MAX = 7'd63;
    localparam logic [6:0] BIT_POS_SAT = 7'd64;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] pct;
        logic [1:0] cat;
        logic [2:0] dtype;
        logic [6:0] bit_acc;
        logic       ovf;
    } pda_state_t;

    localparam pda_state_t STATE_RESET = '{
        phase:   PH_PREFIX,
        pct:     2'd0,
        cat:     CAT_I,
        dtype:   DT_X,
        bit_acc: 7'd0,
        ovf:     1'b0
    };

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] u;
        begin
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                u = c - CASE_OFFSET;
            else
                u = c;
            return u;
        end
    endfunction

    // {hit, code}
    function automatic logic [2:0] cat_lookup(input logic [7:0] u);
        logic [2:0] r;
        begin
            case (u)
                8'h49:   r = {1'b1, CAT_I}; // I
                8'h51:   r = {1'b1, CAT_Q}; // Q
                8'h4D:   r = {1'b1, CAT_M}; // M
                8'h53:   r = {1'b1, CAT_S}; // S
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

    // {hit, code}
    function automatic logic [3:0] type_lookup(input logic [7:0] u);
        logic [3:0] r;
        begin
            case (u)
                8'h58:   r = {1'b1, DT_X}; // X
                8'h42:   r = {1'b1, DT_B}; // B
                8'h57:   r = {1'b1, DT_W}; // W
                8'h44:   r = {1'b1, DT_D}; // D
                8'h4C:   r = {1'b1, DT_L}; // L
                8'h52:   r = {1'b1, DT_R}; // R
                8'h46:   r = {1'b1, DT_F}; // F
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/plc_direct_address_parser.sv -----
// plc_direct_address_parser: top level of the controller direct address parser.
// Depends on pda_pkg and pda_char_step.

// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  -------------------------------------------
// input     in         in_valid / in_stall  char_code[7:0], final_char
// result    out        out_valid/out_stall  ok, error_code, category, data_type,
//                                           index_value[63:0], has_bit, bit_position
//
// One character per cycle while in_stall is low. Each character's parse step
// (category/type decode and the times-ten-plus-digit shift-add on the index) runs
// between the parse state registers and the result register, so the result appears
// in the cycle after its last character is taken.
// Reset (rst_n low, asynchronous) returns the parser to the prefix phase and empties
// the result register. in_stall rises only while a result is held and out_stall is
// high; a transaction is taken in the same cycle the held result leaves.

module plc_direct_address_parser #(
    parameter int INDEX_WIDTH = pda_pkg::IndexWidthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        final_char,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [2:0]  error_code,
    output logic [1:0]  category,
    output logic [2:0]  data_type,
    output logic [63:0] index_value,
    output logic        has_bit,
    output logic [5:0]  bit_position
);

    pda_pkg::pda_state_t    state_reg;
    pda_pkg::pda_state_t    state_next;
    pda_pkg::pda_state_t    step_state;
    logic [INDEX_WIDTH-1:0] idx_reg;
    logic [INDEX_WIDTH-1:0] idx_next;
    logic [INDEX_WIDTH-1:0] step_idx;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   ok_reg;
    logic [2:0]             error_code_reg;
    logic [1:0]             category_reg;
    logic [2:0]             data_type_reg;
    logic [63:0]            index_value_reg;
    logic                   has_bit_reg;
    logic [5:0]             bit_position_reg;

    logic                   accept;
    logic                   emit;
    logic                   res_has_bit;
    logic [2:0]             res_err;

    // held result that cannot leave blocks the next transaction
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign emit     = accept && final_char;

    pda_char_step #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_step (
        .cur       (state_reg),
        .cur_idx   (idx_reg),
        .char_code (char_code),
        .nxt       (step_state),
        .nxt_idx   (step_idx)
    );

    // end-of-string checks, format first, then overflow, bit range, bit on non-bit type
    always_comb
    begin
        res_has_bit = (step_state.phase == pda_pkg::PH_BIT);
        if (step_state.phase == pda_pkg::PH_PREFIX || step_state.phase == pda_pkg::PH_DOT ||
            step_state.phase == pda_pkg::PH_FAIL)
            res_err = pda_pkg::ERR_FORMAT;
        else if (step_state.ovf)
            res_err = pda_pkg::ERR_OVERFLOW;
        else if (res_has_bit && (step_state.bit_acc > pda_pkg::BIT_POS_MAX))
            res_err = pda_pkg::ERR_BIT_RANGE;
        else if (res_has_bit && (step_state.dtype != pda_pkg::DT_X))
            res_err = pda_pkg::ERR_BIT_TYPE;
        else
            res_err = pda_pkg::ERR_NONE;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (accept)
        begin
            if (final_char)
            begin
                state_next = pda_pkg::STATE_RESET;
                idx_next   = '0;
            end
            else
            begin
                state_next = step_state;
                idx_next   = step_idx;
            end
        end

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pda_pkg::STATE_RESET;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload; fields other than the error code read zero on a failed parse
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            error_code_reg <= res_err;
            if (res_err == pda_pkg::ERR_NONE)
            begin
                ok_reg           <= 1'b1;
                category_reg     <= step_state.cat;
                data_type_reg    <= step_state.dtype;
                index_value_reg  <= 64'(step_idx);
                has_bit_reg      <= res_has_bit;
                bit_position_reg <= res_has_bit ? step_state.bit_acc[5:0] : 6'd0;
            end
            else
            begin
                ok_reg           <= 1'b0;
                category_reg     <= 2'd0;
                data_type_reg    <= 3'd0;
                index_value_reg  <= 64'd0;
                has_bit_reg      <= 1'b0;
                bit_position_reg <= 6'd0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign error_code   = error_code_reg;
    assign category     = category_reg;
    assign data_type    = data_type_reg;
    assign index_value  = index_value_reg;
    assign has_bit      = has_bit_reg;
    assign bit_position = bit_position_reg;

endmodule

// ----- rtl/pda_char_step.sv -----
// pda_char_step: next parse state for one address character.
// Depends on pda_pkg.

module pda_char_step #(
    parameter int INDEX_WIDTH = pda_pkg::IndexWidthDefault
) (
    input  pda_pkg::pda_state_t     cur,
    input  logic [INDEX_WIDTH-1:0]  cur_idx,
    input  logic [7:0]              char_code,
    output pda_pkg::pda_state_t     nxt,
    output logic [INDEX_WIDTH-1:0]  nxt_idx
);

    logic [7:0]             upper;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [2:0]             cat_hit;
    logic [3:0]             type_hit;
    logic [INDEX_WIDTH+3:0] idx_wide;
    logic [INDEX_WIDTH+3:0] idx_prod;
    logic                   idx_over;
    logic [9:0]             bit_wide;
    logic [9:0]             bit_prod;
    logic                   take_index;
    logic                   take_bit;

    always_comb
    begin
        upper    = pda_pkg::to_upper(char_code);
        is_digit = (char_code >= pda_pkg::CHAR_ZERO) && (char_code <= pda_pkg::CHAR_NINE);
        digit    = char_code[3:0];
        cat_hit  = pda_pkg::cat_lookup(upper);
        type_hit = pda_pkg::type_lookup(upper);

        // acc * 10 + d by shift-add; overflow when anything lands above the index width
        idx_wide = {4'd0, cur_idx};
        idx_prod = (idx_wide << 3) + (idx_wide << 1) + {{INDEX_WIDTH{1'b0}}, digit};
        idx_over = |idx_prod[INDEX_WIDTH+3:INDEX_WIDTH];

        bit_wide = {4'd0, cur.bit_acc[5:0]};
        bit_prod = (bit_wide << 3) + (bit_wide << 1) + {6'd0, digit};
    end

    always_comb
    begin
        nxt        = cur;
        take_index = 1'b0;
        take_bit   = 1'b0;
        case (cur.phase)
            pda_pkg::PH_PREFIX:
            begin
                if (char_code == pda_pkg::CHAR_PERCENT)
                begin
                    if (cur.pct < pda_pkg::PERCENT_MAX)
                        nxt.pct = cur.pct + 2'd1;
                    else
                        nxt.phase = pda_pkg::PH_FAIL;
                end
                else if (cat_hit[2])
                begin
                    nxt.cat   = cat_hit[1:0];
                    nxt.phase = pda_pkg::PH_AFTER_CAT;
                end
                else
                    nxt.phase = pda_pkg::PH_FAIL;
            end
            pda_pkg::PH_AFTER_CAT:
            begin
                if (type_hit[3])
                begin
                    nxt.dtype = type_hit[2:0];
                    nxt.phase = pda_pkg::PH_AFTER_TYPE;
                end
                else if (is_digit)
                begin
                    take_index = 1'b1;
                    nxt.phase  = pda_pkg::PH_INDEX;
                end
                else
                    nxt.phase = pda_pkg::PH_FAIL;
            end
            pda_pkg::PH_AFTER_TYPE:
            begin
                if (is_digit)
                begin
                    take_index = 1'b1;
                    nxt.phase  = pda_pkg::PH_INDEX;
                end
                else
                    nxt.phase = pda_pkg::PH_FAIL;
            end
            pda_pkg::PH_INDEX:
            begin
                if (is_digit)
                    take_index = 1'b1;
                else if (char_code == pda_pkg::CHAR_DOT)
                    nxt.phase = pda_pkg::PH_DOT;
                else
                    nxt.phase = pda_pkg::PH_FAIL;
            end
            pda_pkg::PH_DOT, pda_pkg::PH_BIT:
            begin
                if (is_digit)
                begin
                    take_bit  = 1'b1;
                    nxt.phase = pda_pkg::PH_BIT;
                end
                else
                    nxt.phase = pda_pkg::PH_FAIL;
            end
            default:
                nxt.phase = pda_pkg::PH_FAIL;
        endcase

        // index accumulator freezes once overflow is flagged
        nxt_idx = cur_idx;
        if (take_index && !cur.ovf)
        begin
            if (idx_over)
                nxt.ovf = 1'b1;
            else
                nxt_idx = idx_prod[INDEX_WIDTH-1:0];
        end

        // bit position saturates at 64
        if (take_bit && (cur.bit_acc <= pda_pkg::BIT_POS_MAX))
        begin
            if (bit_prod > 10'd63)
                nxt.bit_acc = pda_pkg::BIT_POS_SAT;
            else
                nxt.bit_acc = bit_prod[6:0];
        end
    end

endmodule
